// ----- design/unicode_encoding_sniffer_top_defines.svh -----
// assertion macros used by the checker file
`ifndef UNICODE_ENCODING_SNIFFER_TOP_DEFINES_SVH
`define UNICODE_ENCODING_SNIFFER_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define UES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define UES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ues_pkg.sv -----
package ues_pkg;

  // counter width of the scan
  localparam int CNT_W = 32;
  // width of the percent values; the products (counter times a 7 bit value) are PROD_W wide
  localparam int PCT_W = 7;
  localparam int PROD_W = CNT_W + PCT_W;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  // verdict codes
  localparam logic [1:0] ENC_UNDET    = 2'd0;
  localparam logic [1:0] ENC_UTF16_LE = 2'd1;
  localparam logic [1:0] ENC_UTF16_BE = 2'd2;
  localparam logic [1:0] ENC_UTF8     = 2'd3;

  // configuration register indexes
  localparam logic CFG_MIN_HITS  = 1'b0;
  localparam logic CFG_BAD_LIMIT = 1'b1;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       encoding_code;
    logic [CNT_W-1:0] utf8_good_total;
    logic [CNT_W-1:0] utf8_bad_total;
    logic [CNT_W-1:0] le_hits_total;
    logic [CNT_W-1:0] be_hits_total;
  } out_word_t;

  // counters of one finished buffer, handed from the scan to the verdict
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] good;
    logic [CNT_W-1:0] bad;
    logic [CNT_W-1:0] le;
    logic [CNT_W-1:0] be;
  } snap_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (&c) ? c : c + CNT_W'(1);
  endfunction

  function automatic logic is_printable(input logic [7:0] b);
    is_printable = (b > 8'h1F) && (b < 8'h7F);
  endfunction

endpackage

// ----- design/ues_scan.sv -----
module ues_scan
  import ues_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     advance,
  input  logic     accept,
  input  in_word_t in_data,
  output snap_t    snap
);

  logic [1:0]       pending;
  logic             seq_ok;
  logic             odd_pos;
  logic [7:0]       pair_first;
  logic [CNT_W-1:0] good_cnt;
  logic [CNT_W-1:0] bad_cnt;
  logic [CNT_W-1:0] le_cnt;
  logic [CNT_W-1:0] be_cnt;

  logic [1:0]       pending_next;
  logic             seq_ok_next;
  logic             odd_pos_next;
  logic [7:0]       pair_first_next;
  logic [CNT_W-1:0] good_cnt_next;
  logic [CNT_W-1:0] bad_cnt_next;
  logic [CNT_W-1:0] le_cnt_next;
  logic [CNT_W-1:0] be_cnt_next;

  logic [7:0] b;
  logic       good_inc;
  logic       bad_inc;
  logic       le_inc;
  logic       be_inc;

  assign b = in_data.byte_value;

  // utf-16 pair check
  always_comb begin
    pair_first_next = pair_first;
    odd_pos_next    = ~odd_pos;
    le_inc          = 1'b0;
    be_inc          = 1'b0;
    if (!odd_pos) begin
      pair_first_next = b;
    end else begin
      be_inc = (pair_first == 8'h00) && is_printable(b);
      le_inc = !be_inc && (b == 8'h00) && is_printable(pair_first);
    end
  end

  // utf-8 lead and continuation walk
  always_comb begin
    pending_next = pending;
    seq_ok_next  = seq_ok;
    good_inc     = 1'b0;
    bad_inc      = 1'b0;
    if (pending != 2'd0) begin
      seq_ok_next  = seq_ok & (b[7:6] == 2'b10);
      pending_next = pending - 2'd1;
      if (pending == 2'd1) begin
        good_inc = seq_ok_next;
        bad_inc  = !seq_ok_next;
      end
    end else begin
      seq_ok_next = 1'b1;
      if (b[7] == 1'b0) begin
        pending_next = 2'd0;
      end else if (b[7:5] == 3'b110) begin
        pending_next = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        pending_next = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        pending_next = 2'd3;
      end else begin
        bad_inc = 1'b1;
      end
    end
  end

  // saturating counters
  always_comb begin
    good_cnt_next = good_inc ? sat_inc(good_cnt) : good_cnt;
    bad_cnt_next  = bad_inc  ? sat_inc(bad_cnt)  : bad_cnt;
    le_cnt_next   = le_inc   ? sat_inc(le_cnt)   : le_cnt;
    be_cnt_next   = be_inc   ? sat_inc(be_cnt)   : be_cnt;
  end

  // scan state, cleared after the final byte of a buffer
  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.last_byte)) begin
      pending    <= 2'd0;
      seq_ok     <= 1'b1;
      odd_pos    <= 1'b0;
      pair_first <= 8'h00;
      good_cnt   <= '0;
      bad_cnt    <= '0;
      le_cnt     <= '0;
      be_cnt     <= '0;
    end else if (accept) begin
      pending    <= pending_next;
      seq_ok     <= seq_ok_next;
      odd_pos    <= odd_pos_next;
      pair_first <= pair_first_next;
      good_cnt   <= good_cnt_next;
      bad_cnt    <= bad_cnt_next;
      le_cnt     <= le_cnt_next;
      be_cnt     <= be_cnt_next;
    end
  end

  // snapshot of the final counters
  always_ff @(posedge clk) begin
    if (advance) begin
      snap.good <= good_cnt_next;
      snap.bad  <= bad_cnt_next;
      snap.le   <= le_cnt_next;
      snap.be   <= be_cnt_next;
    end
    if (rst) begin
      snap.valid <= 1'b0;
    end else if (advance) begin
      snap.valid <= accept && in_data.last_byte;
    end
  end

endmodule

// ----- design/ues_verdict.sv -----
module ues_verdict
  import ues_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  snap_t            snap,
  input  logic [7:0]       min_hits,
  input  logic [PCT_W-1:0] bad_limit,
  output logic             res_valid,
  output out_word_t        res_word
);

  logic [CNT_W-1:0]  good_q;
  logic [CNT_W-1:0]  bad_q;
  logic [CNT_W-1:0]  le_q;
  logic [CNT_W-1:0]  be_q;
  logic              pick_le;
  logic              pick_be;
  logic              bad_zero;
  logic              good_nz;
  logic [PROD_W-1:0] bad_scaled;
  logic [PROD_W-1:0] good_scaled;

  // stage one: hit decisions and the two percent products
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= snap.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      good_q      <= snap.good;
      bad_q       <= snap.bad;
      le_q        <= snap.le;
      be_q        <= snap.be;
      pick_le     <= (snap.be == '0) && (snap.le >= CNT_W'(min_hits));
      pick_be     <= (snap.le == '0) && (snap.be >= CNT_W'(min_hits));
      bad_zero    <= (snap.bad == '0);
      good_nz     <= (snap.good != '0);
      bad_scaled  <= PROD_W'(snap.bad) * PROD_W'(PCT_SCALE);
      good_scaled <= PROD_W'(snap.good) * PROD_W'(bad_limit);
    end
  end

  // stage two: verdict priority
  always_comb begin
    res_word.utf8_good_total = good_q;
    res_word.utf8_bad_total  = bad_q;
    res_word.le_hits_total   = le_q;
    res_word.be_hits_total   = be_q;
    if (pick_le) begin
      res_word.encoding_code = ENC_UTF16_LE;
    end else if (pick_be) begin
      res_word.encoding_code = ENC_UTF16_BE;
    end else if (bad_zero || (good_nz && (bad_scaled < good_scaled))) begin
      res_word.encoding_code = ENC_UTF8;
    end else begin
      res_word.encoding_code = ENC_UNDET;
    end
  end

endmodule

// ----- design/unicode_encoding_sniffer_top.sv -----
// Text encoding sniffer: one byte of a buffer per input word, last_byte set
// on the final byte. Both utf-16 byte-pair hits and utf-8 sequence counts
// are gathered while the buffer streams in; the final byte produces exactly
// one output word with the verdict code and the four saturating counters.
// Bytes without last_byte produce no output word.
// Input: in_valid/in_ready/in_data. Output: out_valid/out_ready/out_data.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 minimum
// utf-16 hits, 1 utf-8 bad percent limit); write only while idle.
// Throughput: one byte per cycle, every cycle, while the output is free.
// The final byte's word passes the scan snapshot (taken at the edge that
// takes the final byte), the percent products and the output register.
// Reset clears the scan state, empties the pipeline and restores the
// register defaults (3 hits, 10 percent).
// When the receiver stalls with a word pending, the whole pipeline holds and
// in_ready drops; an empty output register keeps bytes flowing.
module unicode_encoding_sniffer_top
  import ues_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [7:0] cfg_data
);

  logic             advance;
  logic             accept;
  logic [7:0]       min_hits;
  logic [PCT_W-1:0] bad_limit;
  snap_t            snap;
  logic             res_valid;
  out_word_t        res_word;

  // pipeline moves whenever the output register can take a word
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_hits  <= 8'd3;
      bad_limit <= 7'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_HITS:  min_hits  <= cfg_data;
        CFG_BAD_LIMIT: bad_limit <= cfg_data[PCT_W-1:0];
        default:       min_hits  <= min_hits;
      endcase
    end
  end

  ues_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .accept  (accept),
    .in_data (in_data),
    .snap    (snap)
  );

  ues_verdict u_verdict (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .snap      (snap),
    .min_hits  (min_hits),
    .bad_limit (bad_limit),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res_word;
    end
  end

endmodule

// ----- design/ues_checker.sv -----
`include "unicode_encoding_sniffer_top_defines.svh"

module ues_checker
  import ues_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data,
  input logic      cfg_we,
  input logic      cfg_index,
  input logic [7:0] cfg_data
);

  // a stalled word holds
  `UES_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed while stalled")

  // a free output never blocks the input
  `UES_ASSERT_NOW(a_in_free, out_ready, in_ready, "input blocked while output is free")

  // little-endian verdict needs no big-endian hits
  `UES_ASSERT_NOW(a_le_clean, out_valid && (out_data.encoding_code == ENC_UTF16_LE), out_data.be_hits_total == '0, "le verdict with be hits")

  // big-endian verdict needs no little-endian hits
  `UES_ASSERT_NOW(a_be_clean, out_valid && (out_data.encoding_code == ENC_UTF16_BE), out_data.le_hits_total == '0, "be verdict with le hits")

  // undetermined only when bad sequences were seen
  `UES_ASSERT_NOW(a_undet_bad, out_valid && (out_data.encoding_code == ENC_UNDET), out_data.utf8_bad_total != '0, "undetermined verdict without bad sequences")

endmodule

bind unicode_encoding_sniffer_top ues_checker u_ues_checker (.*);
